/* sv/iscf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iscf_pkg
// Shared constants and types for the sensor sample capture fifo
// ----------------------------------------------------------------------------
package iscf_pkg;

    localparam int DEPTH_LOG2 = 6;
    localparam int FIFO_SIZE  = 1 << DEPTH_LOG2;
    localparam int PTR_W      = DEPTH_LOG2 + 1;
    localparam int BURST_LEN  = 14;
    localparam int BURST_HELD = BURST_LEN - 1;
    localparam int POS_W      = 4;
    localparam int FILL_W     = 7;
    localparam int ACT_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int AXIS_W     = 16;
    localparam int TIME_W     = 64;

    localparam logic [ACT_W-1:0] ACT_DATA  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ABORT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BURST_HELD);

    typedef logic [DEPTH_LOG2-1:0] t_slot;
    typedef logic [PTR_W-1:0]      t_ptr;

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] gyro_x;
        logic signed [AXIS_W-1:0] gyro_y;
        logic signed [AXIS_W-1:0] gyro_z;
        logic [TIME_W-1:0]        stamp;
    } t_sample;

    typedef struct packed {
        logic  wr_en;
        t_slot wr_addr;
        logic  rd_en;
        t_slot rd_addr;
    } t_ram_ctrl;

endpackage
`default_nettype wire

/* sv/iscf_sample_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iscf_sample_ram
// Sample storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module iscf_sample_ram (
    input  wire logic                i_clk,
    input  wire iscf_pkg::t_ram_ctrl i_ctrl,
    input  wire iscf_pkg::t_sample   i_wr_data,
    output iscf_pkg::t_sample        o_rd_data
);
    import iscf_pkg::*;

    t_sample r_mem [FIFO_SIZE];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_ctrl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* sv/imu_sample_capture_fifo_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_capture_fifo_core
// Assembles 14-byte sensor bursts into samples and queues them in a ring
// buffer that drops the oldest entry when full
// a pop result is registered in the input register and then in the result
// registers, which drive the strobe and the output fields
// throughput: one transfer per cycle, busy is never raised
// the result strobe lasts one cycle, the receiver cannot stall
// synchronous active-low reset empties the buffer and the partial burst
// ----------------------------------------------------------------------------
module imu_sample_capture_fifo_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [iscf_pkg::ACT_W-1:0]   i_action,
    input  wire logic [iscf_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [iscf_pkg::TIME_W-1:0]  i_timestamp,
    output logic                              o_done,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_accel_x,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_accel_y,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_accel_z,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_gyro_x,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_gyro_y,
    output logic signed [iscf_pkg::AXIS_W-1:0] o_gyro_z,
    output logic [iscf_pkg::TIME_W-1:0]       o_sample_time,
    output logic                              o_sample_valid,
    output logic [iscf_pkg::FILL_W-1:0]       o_fill_level
);
    import iscf_pkg::*;

    logic              r_in_vld;
    logic [ACT_W-1:0]  r_action;
    logic [BYTE_W-1:0] r_byte;
    logic [TIME_W-1:0] r_ts;

    t_ptr              r_wp, n_wp;
    t_ptr              r_rp, n_rp;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_burst [BURST_HELD];

    logic              r_done;
    logic              r_hit;
    logic [FILL_W-1:0] r_fill;

    t_ptr      count;
    t_ptr      n_count;
    logic      is_data;
    logic      push;
    logic      pop;
    logic      pop_hit;
    t_ram_ctrl ram_ctrl;
    t_sample   wr_sample;
    t_sample   rd_sample;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start;
        end
        r_action <= i_action;
        r_byte   <= i_data_byte;
        r_ts     <= i_timestamp;
    end

    assign count   = r_wp - r_rp;
    assign is_data = r_in_vld && (r_action == ACT_DATA);
    assign push    = is_data && (r_pos >= POS_LAST);
    assign pop     = r_in_vld && (r_action == ACT_POP);
    assign pop_hit = pop && (count != '0);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_pos = r_pos;
        if (r_in_vld) begin
            unique case (r_action)
                ACT_DATA: begin
                    if (push) begin
                        n_wp  = r_wp + 1'b1;
                        n_pos = '0;
                        if (count[DEPTH_LOG2]) begin
                            n_rp = r_rp + 1'b1;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                ACT_POP: begin
                    if (pop_hit) begin
                        n_rp = r_rp + 1'b1;
                    end
                end
                ACT_ABORT: begin
                    n_pos = '0;
                end
                ACT_NOP: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    assign n_count = n_wp - n_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_pos  <= '0;
            r_done <= 1'b0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_pos  <= n_pos;
            r_done <= pop;
        end
        r_hit  <= pop_hit;
        r_fill <= FILL_W'(n_count);
        if (is_data && !push) begin
            r_burst[r_pos] <= r_byte;
        end
    end

    assign wr_sample.accel_x = {r_burst[0], r_burst[1]};
    assign wr_sample.accel_y = {r_burst[2], r_burst[3]};
    assign wr_sample.accel_z = {r_burst[4], r_burst[5]};
    assign wr_sample.gyro_x  = {r_burst[8], r_burst[9]};
    assign wr_sample.gyro_y  = {r_burst[10], r_burst[11]};
    assign wr_sample.gyro_z  = {r_burst[12], r_byte};
    assign wr_sample.stamp   = r_ts;

    assign ram_ctrl.wr_en   = push;
    assign ram_ctrl.wr_addr = r_wp[DEPTH_LOG2-1:0];
    assign ram_ctrl.rd_en   = pop_hit;
    assign ram_ctrl.rd_addr = r_rp[DEPTH_LOG2-1:0];

    iscf_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_ctrl    (ram_ctrl),
        .i_wr_data (wr_sample),
        .o_rd_data (rd_sample)
    );

    assign o_done         = r_done;
    assign o_sample_valid = r_hit;
    assign o_fill_level   = r_fill;
    assign o_accel_x      = r_hit ? rd_sample.accel_x : '0;
    assign o_accel_y      = r_hit ? rd_sample.accel_y : '0;
    assign o_accel_z      = r_hit ? rd_sample.accel_z : '0;
    assign o_gyro_x       = r_hit ? rd_sample.gyro_x  : '0;
    assign o_gyro_y       = r_hit ? rd_sample.gyro_y  : '0;
    assign o_gyro_z       = r_hit ? rd_sample.gyro_z  : '0;
    assign o_sample_time  = r_hit ? rd_sample.stamp   : '0;

endmodule
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for imu_sample_capture_fifo_core. A short directed
// table covers reset, the extreme burst values, empty pops, an abort and a
// pop inside a partial burst. Random bursts with random content then fill
// the ring past overflow, drain it and mix pops, broken bursts and idle
// commands. A local ring buffer model predicts each pop result the table does
// not give, and each strobed result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import iscf_pkg::*;

    typedef struct {
        t_sample           smp;
        logic              valid;
        logic [FILL_W-1:0] fill;
    } t_pop_result;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [BYTE_W-1:0] data;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        t_pop_result       want;
    } t_stim_row;

    localparam logic [TIME_W-1:0] STAMP_MAX = '1;
    localparam logic [8*BURST_LEN-1:0] EXTREME_BURST =
        112'h7FFF_8000_FFFF_A55A_0000_0001_FF00;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      start       = 1'b0;
    logic                      busy;
    logic [ACT_W-1:0]          i_action    = ACT_NOP;
    logic [BYTE_W-1:0]         i_data_byte = '0;
    logic [TIME_W-1:0]         i_timestamp = '0;
    logic                      o_done;
    logic signed [AXIS_W-1:0]  o_accel_x;
    logic signed [AXIS_W-1:0]  o_accel_y;
    logic signed [AXIS_W-1:0]  o_accel_z;
    logic signed [AXIS_W-1:0]  o_gyro_x;
    logic signed [AXIS_W-1:0]  o_gyro_y;
    logic signed [AXIS_W-1:0]  o_gyro_z;
    logic [TIME_W-1:0]         o_sample_time;
    logic                      o_sample_valid;
    logic [FILL_W-1:0]         o_fill_level;

    // ring buffer model
    t_sample           ring [FIFO_SIZE];
    t_ptr              wr_ptr     = '0;
    t_ptr              rd_ptr     = '0;
    logic [POS_W-1:0]  byte_count = '0;
    logic [BYTE_W-1:0] burst_buf [BURST_HELD];
    int                dropped    = 0;

    t_pop_result       popped_due [$];
    t_stim_row         plan [$];
    t_pop_result       empty_pop;
    int                mismatches  = 0;
    int                sent        = 0;
    int                steady_left = 0;

    imu_sample_capture_fifo_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .i_timestamp    (i_timestamp),
        .o_done         (o_done),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_gyro_x       (o_gyro_x),
        .o_gyro_y       (o_gyro_y),
        .o_gyro_z       (o_gyro_z),
        .o_sample_time  (o_sample_time),
        .o_sample_valid (o_sample_valid),
        .o_fill_level   (o_fill_level)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_ptr held();
        return wr_ptr - rd_ptr;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [TIME_W-1:0] rand_stamp();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit advance_capture(input logic [ACT_W-1:0] act,
            input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] stamp,
            output t_pop_result res);
        t_sample s;
        bit      has_res;
        has_res   = 1'b0;
        res.smp   = '0;
        res.valid = 1'b0;
        res.fill  = '0;
        case (act)
            ACT_DATA: begin
                if (byte_count == POS_LAST) begin
                    if (held() >= t_ptr'(FIFO_SIZE)) begin
                        rd_ptr = rd_ptr + 1'b1;
                        dropped++;
                    end
                    // temperature bytes 6 and 7 are skipped
                    s.accel_x = {burst_buf[0], burst_buf[1]};
                    s.accel_y = {burst_buf[2], burst_buf[3]};
                    s.accel_z = {burst_buf[4], burst_buf[5]};
                    s.gyro_x  = {burst_buf[8], burst_buf[9]};
                    s.gyro_y  = {burst_buf[10], burst_buf[11]};
                    s.gyro_z  = {burst_buf[12], data};
                    s.stamp   = stamp;
                    ring[wr_ptr[DEPTH_LOG2-1:0]] = s;
                    wr_ptr     = wr_ptr + 1'b1;
                    byte_count = '0;
                end else begin
                    burst_buf[byte_count] = data;
                    byte_count = byte_count + 1'b1;
                end
            end
            ACT_ABORT: byte_count = '0;
            ACT_POP: begin
                has_res = 1'b1;
                if (held() != '0) begin
                    res.smp   = ring[rd_ptr[DEPTH_LOG2-1:0]];
                    res.valid = 1'b1;
                    rd_ptr    = rd_ptr + 1'b1;
                end
                res.fill = FILL_W'(held());
            end
            default: ;
        endcase
        return has_res;
    endfunction

    function automatic void add_row(input logic [ACT_W-1:0] act,
            input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] stamp,
            input bit typed, input t_pop_result want);
        t_stim_row row;
        row.act   = act;
        row.data  = data;
        row.stamp = stamp;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    task automatic send_transfer(input logic [ACT_W-1:0] act,
            input logic [BYTE_W-1:0] data, input logic [TIME_W-1:0] stamp,
            input bit typed, input t_pop_result want);
        int          gap;
        t_pop_result res;
        if (steady_left > 0) begin
            gap = 0;
            steady_left--;
        end else begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0) begin
                steady_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_data_byte <= data;
        i_timestamp <= stamp;
        do @(posedge i_clk); while (busy);
        sent++;
        if (advance_capture(act, data, stamp, res)) begin
            popped_due.push_back(typed ? want : res);
        end
    endtask

    task automatic send_pop();
        send_transfer(ACT_POP, rand_byte(), rand_stamp(), 1'b0, empty_pop);
    endtask

    task automatic send_burst(input int cut, input int pop_at);
        for (int k = 0; k < cut; k++) begin
            if (k == pop_at) begin
                send_pop();
            end
            send_transfer(ACT_DATA, rand_byte(), rand_stamp(), 1'b0, empty_pop);
        end
    endtask

    task automatic send_abort();
        send_transfer(ACT_ABORT, rand_byte(), rand_stamp(), 1'b0, empty_pop);
    endtask

    // resync on a leftover partial burst, then one whole burst
    task automatic send_sample();
        if (byte_count != '0) begin
            send_abort();
        end
        send_burst(BURST_LEN,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, BURST_HELD) : -1);
    endtask

    task automatic send_broken();
        send_burst($urandom_range(1, BURST_HELD),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, BURST_HELD) : -1);
        if ($urandom_range(0, 1) == 1) begin
            send_abort();
        end
    endtask

    task automatic send_noise();
        send_transfer(ACT_W'($urandom_range(ACT_DATA, ACT_NOP)), rand_byte(),
                      rand_stamp(), 1'b0, empty_pop);
    endtask

    task automatic drain();
        while (held() != '0) begin
            send_pop();
        end
        send_pop();
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
            input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pop_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (popped_due.size() == 0) begin
                $error("pop result transfer with nothing expected");
                mismatches++;
            end else begin
                want = popped_due.pop_front();
                compare_field("accel_x", TIME_W'(want.smp.accel_x), TIME_W'(o_accel_x));
                compare_field("accel_y", TIME_W'(want.smp.accel_y), TIME_W'(o_accel_y));
                compare_field("accel_z", TIME_W'(want.smp.accel_z), TIME_W'(o_accel_z));
                compare_field("gyro_x", TIME_W'(want.smp.gyro_x), TIME_W'(o_gyro_x));
                compare_field("gyro_y", TIME_W'(want.smp.gyro_y), TIME_W'(o_gyro_y));
                compare_field("gyro_z", TIME_W'(want.smp.gyro_z), TIME_W'(o_gyro_z));
                compare_field("sample_time", want.smp.stamp, o_sample_time);
                compare_field("sample_valid", TIME_W'(want.valid),
                              TIME_W'(o_sample_valid));
                compare_field("fill_level", TIME_W'(want.fill), TIME_W'(o_fill_level));
            end
        end
    end

    initial begin
        t_pop_result extreme;
        int          mark;
        empty_pop.smp   = '0;
        empty_pop.valid = 1'b0;
        empty_pop.fill  = '0;
        extreme.smp     = '{accel_x: 16'h7FFF, accel_y: 16'h8000, accel_z: 16'hFFFF,
                            gyro_x: 16'h0000, gyro_y: 16'h0001, gyro_z: 16'hFF00,
                            stamp: STAMP_MAX};
        extreme.valid   = 1'b1;
        extreme.fill    = '0;

        // pop on empty after reset, abort with nothing pending, idle command
        add_row(ACT_POP, 8'h00, '0, 1'b1, empty_pop);
        add_row(ACT_ABORT, 8'hFF, STAMP_MAX, 1'b0, empty_pop);
        add_row(ACT_NOP, 8'hA5, STAMP_MAX, 1'b0, empty_pop);
        for (int k = 0; k < BURST_LEN; k++) begin
            add_row(ACT_DATA, EXTREME_BURST[8*(BURST_LEN-1-k) +: 8],
                    (k == BURST_LEN - 1) ? STAMP_MAX : '0, 1'b0, empty_pop);
        end
        // partial burst, pop served in the middle of it, then dropped
        for (int k = 0; k < 3; k++) begin
            add_row(ACT_DATA, 8'h5A, '0, 1'b0, empty_pop);
        end
        add_row(ACT_POP, 8'h00, '0, 1'b1, extreme);
        add_row(ACT_POP, 8'h00, '0, 1'b1, empty_pop);
        add_row(ACT_ABORT, 8'h00, '0, 1'b0, empty_pop);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_transfer(plan[i].act, plan[i].data, plan[i].stamp, plan[i].typed,
                          plan[i].want);
        end

        // fill past full so the oldest entries are overwritten
        while (dropped < 4) begin
            case ($urandom_range(0, 19))
                0: send_broken();
                1: send_noise();
                2: send_pop();
                default: send_sample();
            endcase
        end
        drain();

        mark = sent;
        while (sent - mark < 60) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_sample();
                4, 5, 6: repeat ($urandom_range(1, 6)) send_pop();
                7: send_broken();
                default: send_noise();
            endcase
        end
        drain();

        start <= 1'b0;
        while (popped_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("imu_sample_capture_fifo_core test passed");
        end else begin
            $display("imu_sample_capture_fifo_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("imu_sample_capture_fifo_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/iscf_pkg.sv
sv/iscf_sample_ram.sv
sv/imu_sample_capture_fifo_core.sv
dv/tb_top.sv
